/* hdl/region_mean_color_tolerance_check_core_defines.svh */
// assertion macros shared by the checker of the region mean color check
`ifndef REGION_MEAN_COLOR_TOLERANCE_CHECK_CORE_DEFINES_SVH
`define REGION_MEAN_COLOR_TOLERANCE_CHECK_CORE_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define RMCTC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while reset is low
`define RMCTC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rmctc_pkg.sv */
// shared types and constants of the region mean color tolerance check
package rmctc_pkg;

  localparam int CHAN_BITS     = 8;
  localparam int NUM_CHAN      = 3;
  localparam int COLOR_BITS    = NUM_CHAN * CHAN_BITS;
  localparam int SUM_BITS      = 32;
  localparam int COUNT_BITS    = 25;
  localparam int TOL_BITS      = 8;
  localparam int SCALED_BITS   = CHAN_BITS + COUNT_BITS;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_IDX_BITS  = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CENTER_X      = 3'd0,
    CFG_CENTER_Y      = 3'd1,
    CFG_REGION_WIDTH  = 3'd2,
    CFG_REGION_HEIGHT = 3'd3,
    CFG_TARGET_COLOR  = 3'd4,
    CFG_TOLERANCE     = 3'd5,
    CFG_ELLIPSE_MODE  = 3'd6
  } cfg_idx_t;

  // controller to datapath commands
  typedef struct packed {
    logic adv;       // pixel pipeline and accumulators advance
    logic chk_load;  // register the scaled target and tolerance products
    logic out_load;  // register the tolerance verdict into the result slot
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic eof_exit;  // last pipeline stage holds the final pixel of a frame
    logic out_free;  // result slot empty or draining this cycle
  } dp_sts_t;

endpackage

/* hdl/rmctc_ctrl.sv */
// controller state machine: pixel streaming and the end-of-frame check steps
module rmctc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  rmctc_pkg::dp_sts_t  sts,
  output rmctc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_MUL,
    ST_CMP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // command decode and next state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_RUN: begin
        cmd.adv = 1'b1;
        if (sts.eof_exit) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.chk_load = 1'b1;
        state_nxt    = ST_CMP;
      end
      ST_CMP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/rmctc_dp.sv */
// datapath: config registers, mask pipeline, accumulators, tolerance check, result slot
module rmctc_dp #(
  parameter int COORD_BITS = 12
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [rmctc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [rmctc_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  input  logic                                    in_valid,
  input  logic [COORD_BITS-1:0]                   in_pix_x,
  input  logic [COORD_BITS-1:0]                   in_pix_y,
  input  logic [rmctc_pkg::CHAN_BITS-1:0]         in_red,
  input  logic [rmctc_pkg::CHAN_BITS-1:0]         in_green,
  input  logic [rmctc_pkg::CHAN_BITS-1:0]         in_blue,
  input  logic                                    in_end_of_frame,
  input  logic                                    out_stall,
  output logic                                    out_valid,
  output logic                                    out_within_tolerance,
  output logic [rmctc_pkg::COUNT_BITS-1:0]        out_masked_count,
  input  rmctc_pkg::dp_cmd_t                      cmd,
  output rmctc_pkg::dp_sts_t                      sts
);

  localparam int HALF_W   = COORD_BITS - 1;
  localparam int SQ_W     = 2 * COORD_BITS;
  localparam int SQH_W    = 2 * HALF_W;
  localparam int PROD_W   = SQ_W + SQH_W;
  localparam int CH_W     = rmctc_pkg::CHAN_BITS;
  localparam int NCH      = rmctc_pkg::NUM_CHAN;
  localparam int COL_W    = rmctc_pkg::COLOR_BITS;
  localparam int SUM_W    = rmctc_pkg::SUM_BITS;
  localparam int CNT_W    = rmctc_pkg::COUNT_BITS;
  localparam int TOL_W    = rmctc_pkg::TOL_BITS;
  localparam int SCL_W    = rmctc_pkg::SCALED_BITS;

  // configuration registers
  logic [COORD_BITS-1:0] cx_r;
  logic [COORD_BITS-1:0] cy_r;
  logic [COORD_BITS-1:0] wid_r;
  logic [COORD_BITS-1:0] hgt_r;
  logic [COL_W-1:0]      target_r;
  logic [TOL_W-1:0]      tol_r;
  logic                  ell_r;

  logic [HALF_W-1:0]     half_w;
  logic [HALF_W-1:0]     half_h;

  // pipeline stage registers
  logic                  s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic                  s1_eof_r, s2_eof_r, s3_eof_r, s4_eof_r, s5_eof_r;
  logic [COL_W-1:0]      s1_col_r, s2_col_r, s3_col_r, s4_col_r, s5_col_r;
  logic [COORD_BITS-1:0] s1_x_r, s1_y_r;
  logic                  s2_rect_r, s3_rect_r, s4_rect_r;
  logic [COORD_BITS-1:0] s2_adx_r, s2_ady_r;
  logic [SQ_W-1:0]       s3_adx2_r, s3_ady2_r;
  logic [SQH_W-1:0]      s3_a2_r, s3_b2_r;
  logic [PROD_W-1:0]     s4_p1_r, s4_p2_r, s4_p3_r;
  logic                  s5_hit_r;

  // stage logic
  logic                  rect_x, rect_y;
  logic [COORD_BITS-1:0] adx, ady;
  logic [SQ_W-1:0]       adx2, ady2;
  logic [SQH_W-1:0]      a2, b2;
  logic [PROD_W-1:0]     p1, p2, p3;
  logic [PROD_W:0]       lhs;
  logic                  hit;

  // accumulators and check registers
  logic [SUM_W-1:0]      sum_r [NCH];
  logic [CNT_W-1:0]      cnt_r;
  logic [SUM_W-1:0]      sum_upd [NCH];
  logic [CNT_W-1:0]      cnt_upd;
  logic [SUM_W-1:0]      chk_sum_r [NCH];
  logic [CNT_W-1:0]      chk_n_r;
  logic [SCL_W-1:0]      chk_tn_r [NCH];
  logic [SCL_W-1:0]      chk_toln_r;
  logic [SCL_W-1:0]      tn [NCH];
  logic [SCL_W-1:0]      toln;
  logic [NCH-1:0]        ch_ok;
  logic                  exit_pix;

  // result slot
  logic                  out_valid_r;
  logic                  out_ok_r;
  logic [CNT_W-1:0]      out_cnt_r;

  assign half_w = wid_r[COORD_BITS-1:1];
  assign half_h = hgt_r[COORD_BITS-1:1];

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      wid_r    <= '0;
      hgt_r    <= '0;
      target_r <= '0;
      tol_r    <= '0;
      ell_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (rmctc_pkg::cfg_idx_t'(cfg_index))
        rmctc_pkg::CFG_CENTER_X:      cx_r     <= cfg_wdata[COORD_BITS-1:0];
        rmctc_pkg::CFG_CENTER_Y:      cy_r     <= cfg_wdata[COORD_BITS-1:0];
        rmctc_pkg::CFG_REGION_WIDTH:  wid_r    <= cfg_wdata[COORD_BITS-1:0];
        rmctc_pkg::CFG_REGION_HEIGHT: hgt_r    <= cfg_wdata[COORD_BITS-1:0];
        rmctc_pkg::CFG_TARGET_COLOR:  target_r <= cfg_wdata[COL_W-1:0];
        rmctc_pkg::CFG_TOLERANCE:     tol_r    <= cfg_wdata[TOL_W-1:0];
        rmctc_pkg::CFG_ELLIPSE_MODE:  ell_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // stage 2: box bounds and absolute offsets from the center
  always_comb begin
    rect_x = (({1'b0, s1_x_r} + {2'b00, half_w}) >= {1'b0, cx_r}) &&
             ({1'b0, s1_x_r} < ({1'b0, cx_r} + {2'b00, half_w}));
    rect_y = (({1'b0, s1_y_r} + {2'b00, half_h}) >= {1'b0, cy_r}) &&
             ({1'b0, s1_y_r} < ({1'b0, cy_r} + {2'b00, half_h}));
    adx    = (s1_x_r >= cx_r) ? (s1_x_r - cx_r) : (cx_r - s1_x_r);
    ady    = (s1_y_r >= cy_r) ? (s1_y_r - cy_r) : (cy_r - s1_y_r);
  end

  // stage 3: squares
  assign adx2 = s2_adx_r * s2_adx_r;
  assign ady2 = s2_ady_r * s2_ady_r;
  assign a2   = half_w * half_w;
  assign b2   = half_h * half_h;

  // stage 4: cross terms of the ellipse test
  assign p1 = s3_adx2_r * s3_b2_r;
  assign p2 = s3_ady2_r * s3_a2_r;
  assign p3 = s3_a2_r * s3_b2_r;

  // stage 5: ellipse compare and final mask bit
  assign lhs = {1'b0, s4_p1_r} + {1'b0, s4_p2_r};
  assign hit = s4_rect_r && (!ell_r || (lhs <= {1'b0, s4_p3_r}));

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (cmd.adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (cmd.adv) begin
      s1_x_r    <= in_pix_x;
      s1_y_r    <= in_pix_y;
      s1_col_r  <= {in_red, in_green, in_blue};
      s1_eof_r  <= in_end_of_frame;
      s2_rect_r <= rect_x && rect_y;
      s2_adx_r  <= adx;
      s2_ady_r  <= ady;
      s2_col_r  <= s1_col_r;
      s2_eof_r  <= s1_eof_r;
      s3_rect_r <= s2_rect_r;
      s3_adx2_r <= adx2;
      s3_ady2_r <= ady2;
      s3_a2_r   <= a2;
      s3_b2_r   <= b2;
      s3_col_r  <= s2_col_r;
      s3_eof_r  <= s2_eof_r;
      s4_rect_r <= s3_rect_r;
      s4_p1_r   <= p1;
      s4_p2_r   <= p2;
      s4_p3_r   <= p3;
      s4_col_r  <= s3_col_r;
      s4_eof_r  <= s3_eof_r;
      s5_hit_r  <= hit;
      s5_col_r  <= s4_col_r;
      s5_eof_r  <= s4_eof_r;
    end
  end

  // saturating channel sums and pixel count
  always_comb begin
    logic [SUM_W:0] add;
    add = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      add = {1'b0, sum_r[ch]} +
            {{(SUM_W + 1 - CH_W){1'b0}}, s5_col_r[ch*CH_W +: CH_W]};
      if (!s5_hit_r) begin
        sum_upd[ch] = sum_r[ch];
      end else if (add[SUM_W]) begin
        sum_upd[ch] = '1;
      end else begin
        sum_upd[ch] = add[SUM_W-1:0];
      end
    end
    cnt_upd = (s5_hit_r && (cnt_r != '1)) ? (cnt_r + 1'b1) : cnt_r;
  end

  assign exit_pix = cmd.adv && s5_v_r;

  // accumulators, cleared after the frame's last pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '{default: '0};
      cnt_r <= '0;
    end else if (exit_pix) begin
      if (s5_eof_r) begin
        sum_r <= '{default: '0};
        cnt_r <= '0;
      end else begin
        sum_r <= sum_upd;
        cnt_r <= cnt_upd;
      end
    end
  end

  // frame totals handed to the check
  always_ff @(posedge clk) begin
    if (exit_pix && s5_eof_r) begin
      chk_sum_r <= sum_upd;
      chk_n_r   <= cnt_upd;
    end
  end

  // check step one: target and tolerance scaled by the count
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      tn[ch] = target_r[ch*CH_W +: CH_W] * chk_n_r;
    end
    toln = tol_r * chk_n_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.chk_load) begin
      chk_tn_r   <= tn;
      chk_toln_r <= toln;
    end
  end

  // check step two: exact mean distance per channel
  always_comb begin
    logic [SCL_W-1:0] sum_e;
    logic [SCL_W-1:0] diff;
    sum_e = '0;
    diff  = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      sum_e = {{(SCL_W - SUM_W){1'b0}}, chk_sum_r[ch]};
      diff  = (chk_tn_r[ch] >= sum_e) ? (chk_tn_r[ch] - sum_e) : (sum_e - chk_tn_r[ch]);
      // empty region: mean taken as zero
      if (chk_n_r == '0) begin
        ch_ok[ch] = tol_r > target_r[ch*CH_W +: CH_W];
      end else begin
        ch_ok[ch] = chk_toln_r > diff;
      end
    end
  end

  // result slot valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result slot payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok_r  <= &ch_ok;
      out_cnt_r <= chk_n_r;
    end
  end

  assign sts.eof_exit = s5_v_r && s5_eof_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid            = out_valid_r;
  assign out_within_tolerance = out_ok_r;
  assign out_masked_count     = out_cnt_r;

endmodule

/* hdl/region_mean_color_tolerance_check_core.sv */
// top level of the region mean color tolerance check
//
//  channel  direction  handshake              payload
//  in       request    in_valid / in_stall    pix_x, pix_y, red, green, blue, end_of_frame
//  out      result     out_valid / out_stall  within_tolerance, masked_count
//  cfg      write      cfg_wr_en              cfg_index, cfg_wdata
//
// one pixel request per cycle through a five-stage mask pipeline
// the final pixel of a frame freezes the input through the scale and compare steps
// and longer while the previous result is still stalled in the result slot
// the result is registered into the result slot at the end of the compare step
// synchronous reset clears config, accumulators and control; no clearing pass
module region_mean_color_tolerance_check_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [rmctc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rmctc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [COORD_BITS-1:0]               in_pix_x,
  input  logic [COORD_BITS-1:0]               in_pix_y,
  input  logic [rmctc_pkg::CHAN_BITS-1:0]     in_red,
  input  logic [rmctc_pkg::CHAN_BITS-1:0]     in_green,
  input  logic [rmctc_pkg::CHAN_BITS-1:0]     in_blue,
  input  logic                                in_end_of_frame,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_within_tolerance,
  output logic [rmctc_pkg::COUNT_BITS-1:0]    out_masked_count
);

  rmctc_pkg::dp_cmd_t cmd;
  rmctc_pkg::dp_sts_t sts;

  // controller
  rmctc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // datapath
  rmctc_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_pix_x             (in_pix_x),
    .in_pix_y             (in_pix_y),
    .in_red               (in_red),
    .in_green             (in_green),
    .in_blue              (in_blue),
    .in_end_of_frame      (in_end_of_frame),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_within_tolerance (out_within_tolerance),
    .out_masked_count     (out_masked_count),
    .cmd                  (cmd),
    .sts                  (sts)
  );

  // requests are taken whenever the pipeline advances
  assign in_stall = !cmd.adv;

endmodule

/* hdl/rmctc_chk.sv */
// port-level checker for the region mean color tolerance check, with its bind
`include "region_mean_color_tolerance_check_core_defines.svh"

module rmctc_chk #(
  parameter int COORD_BITS = 12
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_wr_en,
  input logic [rmctc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input logic [rmctc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [COORD_BITS-1:0]               in_pix_x,
  input logic [COORD_BITS-1:0]               in_pix_y,
  input logic [rmctc_pkg::CHAN_BITS-1:0]     in_red,
  input logic [rmctc_pkg::CHAN_BITS-1:0]     in_green,
  input logic [rmctc_pkg::CHAN_BITS-1:0]     in_blue,
  input logic                                in_end_of_frame,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                out_within_tolerance,
  input logic [rmctc_pkg::COUNT_BITS-1:0]    out_masked_count
);

  // a stalled result holds
  `RMCTC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_within_tolerance) && $stable(out_masked_count), "stalled result changed")

  // the frame-end check keeps the input frozen through both the scale and the compare step
  `RMCTC_ASSERT_NEXT(a_stall_min, clk, rst_n, $rose(in_stall), in_stall, "input freeze shorter than two cycles")

  // input resumes only together with a fresh result
  `RMCTC_ASSERT_NOW(a_resume_result, clk, rst_n, $fell(in_stall), out_valid, "input resumed without a result")

  // a new result only comes out of a frozen input
  `RMCTC_ASSERT_NOW(a_result_origin, clk, rst_n, $rose(out_valid), $past(in_stall), "result without frame-end check")

endmodule

bind region_mean_color_tolerance_check_core rmctc_chk #(
  .COORD_BITS (COORD_BITS)
) u_rmctc_chk (.*);
